@@ rtl/binary_heap_priority_queue_top_assert.svh @@
// ----------------------------------------------------------------------------
// binary heap priority queue assertion macros
// shared property wrappers, clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define BHPQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// same-cycle implication
`define BHPQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BHPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bhpq_pkg
// sizes, codes and state type of the binary heap priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhpq_pkg;

   // heap geometry
   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CH_W   = IDX_W + 2;
   localparam int DATA_W = 32;

   // action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_DELETE = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_UP_PUT,
      ST_DN_LAST_RD,
      ST_DN_LAST,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_DONE
   } state_type;

endpackage

@@ rtl/bhpq_ram.sv @@
// ----------------------------------------------------------------------------
// bhpq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bhpq_cmp.sv @@
// ----------------------------------------------------------------------------
// bhpq_cmp
// shared order compare: true when a belongs above b in the current order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhpq_cmp import bhpq_pkg::*; (
   input  logic                     min_order,
   input  logic signed [DATA_W-1:0] a,
   input  logic signed [DATA_W-1:0] b,
   output logic                     precedes
);

   logic lt;
   logic gt;

   // signed two's complement compares
   assign lt = (a < b);
   assign gt = (a > b);

   // pick the sense by heap order
   assign precedes = min_order ? lt : gt;

endmodule

@@ rtl/binary_heap_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// binary heap priority queue
// array heap in a ram, sifted by a sequencer around one shared compare unit
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  action, value
//   rsp       out         rsp_valid/rsp_stall  status, removed_value, top_value, count
//   csr       in          csr_wr_en            min_order
//
// the request side stalls from an accepted word until its result word is loaded;
// an insert climbs level by level toward the root and may stop short of it, a delete
// moves the last entry to the root and sinks it level by level toward a leaf and may
// stop above one; failed operations and removing the last entry skip the sift.
// reset clears count, order (min), the sequencer and the result valid; no ram clear.
// a stalled result word holds; the next request is still taken, its result then waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "binary_heap_priority_queue_top_assert.svh"

module binary_heap_priority_queue_top import bhpq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_removed_value,
   output logic signed [DATA_W-1:0] rsp_top_value,
   output logic [CNT_W-1:0]         rsp_count,
   input  logic                     csr_wr_en,
   input  logic                     csr_wr_data
);

   state_type state_ff, state_in;

   logic                     min_order_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [IDX_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0] x_ff;
   logic signed [DATA_W-1:0] root_ff;
   logic signed [DATA_W-1:0] best_val_ff;
   logic                     best_l_ff;
   logic                     r_ok_ff;
   logic [1:0]               status_ff;
   logic signed [DATA_W-1:0] removed_ff;

   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_removed_ff;
   logic signed [DATA_W-1:0] rsp_top_ff;
   logic [CNT_W-1:0]         rsp_count_ff;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [DATA_W-1:0] rd_data;

   logic signed [DATA_W-1:0] cmp_a;
   logic signed [DATA_W-1:0] cmp_b;
   logic                     cmp_hit;

   logic                     req_take;
   logic                     out_free;
   logic                     full;
   logic [IDX_W-1:0]         parent;
   logic [CH_W-1:0]          left_w;
   logic [CH_W-1:0]          right_w;
   logic [CH_W-1:0]          cnt_w;
   logic                     l_ok;
   logic                     r_ok;
   logic                     take_r;
   logic                     move_dn;

   // handshake and index arithmetic
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign parent    = IDX_W'((pos_ff - IDX_W'(1)) >> 1);
   assign left_w    = {1'b0, pos_ff, 1'b1};
   assign right_w   = left_w + CH_W'(1);
   assign cnt_w     = CH_W'(cnt_ff);
   assign l_ok      = (left_w < cnt_w);
   assign r_ok      = (right_w < cnt_w);
   assign take_r    = r_ok_ff && cmp_hit;
   assign move_dn   = take_r || best_l_ff;

   // heap store
   bhpq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared compare unit
   bhpq_cmp u_cmp (
      .min_order (min_order_ff),
      .a         (cmp_a),
      .b         (cmp_b),
      .precedes  (cmp_hit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_action == ACT_INSERT) begin
                  if (full) begin
                     state_in = ST_DONE;
                  end else if (cnt_ff == '0) begin
                     state_in = ST_UP_PUT;
                  end else begin
                     state_in = ST_UP_RD;
                  end
               end else begin
                  if (cnt_ff == '0 || cnt_ff == CNT_W'(1)) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_DN_LAST_RD;
                  end
               end
            end
         end
         ST_UP_RD:      state_in = ST_UP_CMP;
         ST_UP_CMP: begin
            if (!cmp_hit) begin
               state_in = ST_DONE;
            end else if (parent == '0) begin
               state_in = ST_UP_PUT;
            end else begin
               state_in = ST_UP_RD;
            end
         end
         ST_UP_PUT:     state_in = ST_DONE;
         ST_DN_LAST_RD: state_in = ST_DN_LAST;
         ST_DN_LAST:    state_in = ST_DN_RDL;
         ST_DN_RDL:     state_in = l_ok ? ST_DN_RDR : ST_DONE;
         ST_DN_RDR:     state_in = ST_DN_CMP;
         ST_DN_CMP:     state_in = move_dn ? ST_DN_RDL : ST_DONE;
         ST_DONE:       state_in = out_free ? ST_IDLE : ST_DONE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // ram and compare controls
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = x_ff;
      rd_en   = 1'b0;
      rd_addr = pos_ff;
      cmp_a   = x_ff;
      cmp_b   = rd_data;
      unique case (state_ff)
         ST_UP_RD: begin
            rd_en   = 1'b1;
            rd_addr = parent;
         end
         ST_UP_CMP: begin
            wr_en   = 1'b1;
            wr_data = cmp_hit ? rd_data : x_ff;
         end
         ST_UP_PUT: begin
            wr_en = 1'b1;
         end
         ST_DN_LAST_RD: begin
            rd_en   = 1'b1;
            rd_addr = cnt_ff[IDX_W-1:0];
         end
         ST_DN_RDL: begin
            rd_en   = l_ok;
            rd_addr = left_w[IDX_W-1:0];
            wr_en   = !l_ok;
         end
         ST_DN_RDR: begin
            rd_en   = r_ok;
            rd_addr = right_w[IDX_W-1:0];
            cmp_a   = rd_data;
            cmp_b   = x_ff;
         end
         ST_DN_CMP: begin
            cmp_a   = rd_data;
            cmp_b   = best_val_ff;
            wr_en   = 1'b1;
            wr_data = take_r ? rd_data : (best_l_ff ? best_val_ff : x_ff);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         min_order_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            min_order_ff <= csr_wr_data;
         end
         if (req_take) begin
            if (req_action == ACT_INSERT && !full) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end else if (req_action == ACT_DELETE && cnt_ff != '0) begin
               cnt_ff <= cnt_ff - CNT_W'(1);
            end
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (wr_en && wr_addr == '0) begin
         root_ff <= wr_data;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               x_ff   <= req_value;
               pos_ff <= cnt_ff[IDX_W-1:0];
               if (req_action == ACT_INSERT) begin
                  removed_ff <= '0;
                  status_ff  <= full ? STATUS_FULL : STATUS_DONE;
               end else if (cnt_ff == '0) begin
                  removed_ff <= '0;
                  status_ff  <= STATUS_EMPTY;
               end else begin
                  removed_ff <= root_ff;
                  status_ff  <= STATUS_DONE;
               end
            end
         end
         ST_UP_CMP: begin
            pos_ff <= parent;
         end
         ST_DN_LAST: begin
            x_ff   <= rd_data;
            pos_ff <= '0;
         end
         ST_DN_RDR: begin
            best_l_ff   <= cmp_hit;
            best_val_ff <= cmp_hit ? rd_data : x_ff;
            r_ok_ff     <= r_ok;
         end
         ST_DN_CMP: begin
            if (take_r) begin
               pos_ff <= right_w[IDX_W-1:0];
            end else if (best_l_ff) begin
               pos_ff <= left_w[IDX_W-1:0];
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_status_ff  <= status_ff;
               rsp_removed_ff <= removed_ff;
               rsp_top_ff     <= (cnt_ff == '0) ? '0 : root_ff;
               rsp_count_ff   <= cnt_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // result word
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_top_value     = rsp_top_ff;
   assign rsp_count         = rsp_count_ff;

   // checks
   `BHPQ_ASSERT_ALWAYS(a_cnt_bound, cnt_ff <= CNT_W'(DEPTH), "heap count above depth")
   `BHPQ_ASSERT_IMPL(a_wr_in_heap, wr_en, CNT_W'(wr_addr) < cnt_ff, "write beyond heap end")
   `BHPQ_ASSERT_NEXT(a_del_shrinks, req_take && req_action == ACT_DELETE && cnt_ff != '0,
                     cnt_ff == $past(cnt_ff) - CNT_W'(1), "delete did not shrink heap")
   `BHPQ_ASSERT_IMPL(a_empty_top, rsp_valid_ff && rsp_count_ff == '0, rsp_top_ff == '0,
                     "empty heap reports nonzero top")
   `BHPQ_ASSERT_IMPL(a_fail_removed, rsp_valid_ff && rsp_status_ff != STATUS_DONE,
                     rsp_removed_ff == '0, "failed operation reports a removed word")

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary heap priority queue. A shadow heap
// predicts every result word; a short table of directed words comes first,
// then phases of random words that fill the heap to full, drain it to empty
// and mix both, under min and max order. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import bhpq_pkg::*; ();

   localparam int RANDOM_WORDS   = 1700;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int NUM_ROWS       = 23;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] removed;
      logic signed [DATA_W-1:0] top;
      logic [CNT_W-1:0]         count;
   } heap_result_type;

   typedef struct packed {
      logic                     act;
      logic signed [DATA_W-1:0] val;
      logic                     typed;
      logic [1:0]               status;
      logic signed [DATA_W-1:0] removed;
      logic signed [DATA_W-1:0] top;
      logic [CNT_W-1:0]         count;
   } stim_row_type;

   // dut ports
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_action = ACT_INSERT;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_removed_value;
   logic signed [DATA_W-1:0] rsp_top_value;
   logic [CNT_W-1:0]         rsp_count;
   logic                     csr_wr_en = 1'b0;
   logic                     csr_wr_data = 1'b1;

   // shadow heap state
   logic signed [DATA_W-1:0] shadow_heap [DEPTH];
   int                       shadow_count = 0;
   logic                     shadow_min = 1'b1;

   heap_result_type replies_due [$];
   stim_row_type    stim_rows [NUM_ROWS];

   // idling control
   logic rsp_calm = 1'b0;
   logic req_calm = 1'b0;
   int   mode_left = 0;
   int   stall_left = 0;

   // bookkeeping
   int fails = 0;
   int quiet_cycles = 0;
   int n_words = 0;
   int n_random = 0;
   int n_checked = 0;
   int n_full = 0;
   int n_empty = 0;
   int n_order_writes = 0;

   binary_heap_priority_queue_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_top_value     (rsp_top_value),
      .rsp_count         (rsp_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #1 clock = ~clock;

   // true when a belongs above b in the current order
   function automatic logic ranks_above(logic signed [DATA_W-1:0] a,
                                        logic signed [DATA_W-1:0] b);
      return shadow_min ? (a < b) : (a > b);
   endfunction

   function automatic void swap_slots(int i, int j);
      logic signed [DATA_W-1:0] t;
      t = shadow_heap[i];
      shadow_heap[i] = shadow_heap[j];
      shadow_heap[j] = t;
   endfunction

   // apply one word to the shadow heap and return the result word it causes
   function automatic heap_result_type run_heap_op(logic act, logic signed [DATA_W-1:0] val);
      heap_result_type r;
      int pos;
      int up;
      int best;
      int kid;
      logic moving;
      r = '0;
      r.status = STATUS_DONE;
      if (act == ACT_INSERT) begin
         if (shadow_count >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            shadow_heap[shadow_count] = val;
            pos = shadow_count;
            shadow_count++;
            moving = 1'b1;
            while (moving && pos > 0) begin
               up = (pos - 1) / 2;
               if (ranks_above(shadow_heap[pos], shadow_heap[up])) begin
                  swap_slots(pos, up);
                  pos = up;
               end else begin
                  moving = 1'b0;
               end
            end
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.removed = shadow_heap[0];
            shadow_count--;
            shadow_heap[0] = shadow_heap[shadow_count];
            pos = 0;
            moving = 1'b1;
            while (moving) begin
               best = pos;
               // left child wins ties, so the right one must strictly precede
               kid = 2 * pos + 1;
               if (kid < shadow_count && ranks_above(shadow_heap[kid], shadow_heap[best]))
                  best = kid;
               kid = 2 * pos + 2;
               if (kid < shadow_count && ranks_above(shadow_heap[kid], shadow_heap[best]))
                  best = kid;
               if (best == pos) begin
                  moving = 1'b0;
               end else begin
                  swap_slots(pos, best);
                  pos = best;
               end
            end
         end
      end
      r.top = (shadow_count != 0) ? shadow_heap[0] : '0;
      r.count = shadow_count[CNT_W-1:0];
      return r;
   endfunction

   // mostly short, now and then long
   function automatic int pick_len();
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(15, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic int pick_gap();
      if (req_calm || $urandom_range(0, 9) < 6)
         return 0;
      return pick_len();
   endfunction

   // full range, clustered small values for ties, extremes, and near zero
   function automatic logic signed [DATA_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1: begin
            return $signed($urandom_range(0, 8)) - 4;
         end
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh0000_0000;
               default: return 32'shFFFF_FFFF;
            endcase
         end
         3, 4: begin
            return $signed($urandom_range(0, 2000)) - 1000;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // present one request word, wait for it to be taken, record its result
   task automatic send_word(logic act, logic signed [DATA_W-1:0] val,
                            logic use_typed, heap_result_type typed);
      int gap;
      heap_result_type r;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_action <= 1'($urandom_range(0, 1));
         req_value <= $urandom;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_value <= val;
      do @(posedge clock); while (req_stall);
      r = run_heap_op(act, val);
      if (r.status == STATUS_FULL)
         n_full++;
      if (r.status == STATUS_EMPTY)
         n_empty++;
      if (use_typed)
         r = typed;
      replies_due = {replies_due, r};
      n_words++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (replies_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // order register, written only with the block idle
   task automatic set_order(logic ord);
      req_valid <= 1'b0;
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= ord;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      shadow_min = ord;
      n_order_writes++;
   endtask

   task automatic random_word(int insert_pct);
      logic act;
      act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_DELETE;
      send_word(act, pick_value(), 1'b0, '0);
      n_random++;
   endtask

   // response stall pattern and calm stretches on both sides
   always @(negedge clock) begin
      if (mode_left == 0) begin
         mode_left <= $urandom_range(50, 300);
         rsp_calm <= ($urandom_range(0, 3) == 0);
         req_calm <= ($urandom_range(0, 3) == 0);
      end else begin
         mode_left <= mode_left - 1;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!rsp_calm && $urandom_range(0, 9) < 3) begin
         rsp_stall <= 1'b1;
         stall_left <= pick_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      heap_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $error("result word with nothing pending");
               fails++;
            end else begin
               want = replies_due.pop_front();
               n_checked++;
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fails++;
               end
               if (rsp_removed_value !== want.removed) begin
                  $error("removed_value: expected %0d, got %0d", want.removed,
                         rsp_removed_value);
                  fails++;
               end
               if (rsp_top_value !== want.top) begin
                  $error("top_value: expected %0d, got %0d", want.top, rsp_top_value);
                  fails++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_count);
                  fails++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int row;
      int phase;
      int extra;
      int span;
      heap_result_type typed;

      // directed words, reset order is min
      stim_rows = '{
         '{ACT_DELETE, 32'sd0,           1'b1, STATUS_EMPTY, 32'sd0,
           32'sd0, 7'd0},
         '{ACT_INSERT, 32'sh7FFF_FFFF,   1'b1, STATUS_DONE, 32'sd0,
           32'sh7FFF_FFFF, 7'd1},
         '{ACT_INSERT, 32'sh8000_0000,   1'b1, STATUS_DONE, 32'sd0,
           32'sh8000_0000, 7'd2},
         '{ACT_INSERT, 32'sd0,           1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_INSERT, 32'shFFFF_FFFF,   1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_INSERT, 32'sd1,           1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_INSERT, 32'sh8000_0000,   1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_DELETE, 32'sd0,           1'b1, STATUS_DONE, 32'sh8000_0000,
           32'sh8000_0000, 7'd5},
         '{ACT_DELETE, 32'sh1234_5678,   1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_DELETE, 32'shFFFF_FFFF,   1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_DELETE, 32'sd0,           1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_DELETE, 32'sd0,           1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_DELETE, 32'sd0,           1'b1, STATUS_DONE, 32'sh7FFF_FFFF,
           32'sd0, 7'd0},
         '{ACT_DELETE, 32'sh7FFF_FFFF,   1'b1, STATUS_EMPTY, 32'sd0,
           32'sd0, 7'd0},
         '{ACT_INSERT, 32'shAAAA_AAAA,   1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_INSERT, 32'sh5555_5555,   1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_INSERT, 32'sd5,           1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_INSERT, 32'sd5,           1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_INSERT, 32'sd5,           1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_DELETE, 32'sd0,           1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_DELETE, 32'sd0,           1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_INSERT, 32'shFFFF_FFFF,   1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0},
         '{ACT_DELETE, 32'sd0,           1'b0, STATUS_DONE, 32'sd0, 32'sd0, 7'd0}
      };

      // reset held at the start, released on a falling edge
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // walk the directed table
      for (row = 0; row < NUM_ROWS; row++) begin
         typed.status = stim_rows[row].status;
         typed.removed = stim_rows[row].removed;
         typed.top = stim_rows[row].top;
         typed.count = stim_rows[row].count;
         send_word(stim_rows[row].act, stim_rows[row].val, stim_rows[row].typed, typed);
      end

      // random phases: fill to full, mix, drain to empty, mix
      // first phase runs max order, second flips to min with the heap still loaded
      phase = 0;
      while (n_random < RANDOM_WORDS) begin
         if (phase < 2)
            set_order(phase == 1);
         else
            set_order(1'($urandom_range(0, 1)));
         case (phase % 4)
            0: begin
               extra = $urandom_range(3, 8);
               while (extra > 0) begin
                  if (shadow_count == DEPTH)
                     extra--;
                  random_word(90);
               end
            end
            2: begin
               extra = $urandom_range(3, 6);
               while (extra > 0) begin
                  if (shadow_count == 0)
                     extra--;
                  random_word(10);
               end
            end
            default: begin
               span = $urandom_range(40, 160);
               repeat (span) random_word(50);
            end
         endcase
         phase++;
      end

      // drain the result side and let the block settle
      req_valid <= 1'b0;
      while (replies_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run: %0d request words (%0d random), %0d results checked, %0d order writes",
               n_words, n_random, n_checked, n_order_writes);
      $display("run: %0d inserts on a full heap, %0d deletes on an empty heap",
               n_full, n_empty);
      if (fails == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
